>>> sv/itc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_pkg
// Types, codes and micro-step tables for the inertia tensor accumulator.
// ----------------------------------------------------------------------------
package itc_pkg;

  localparam int ID_BITS_DEF = 16;
  localparam int AGG_W       = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int N_SUMS      = 9;
  localparam int TERM_W      = 54;
  localparam int WIDE_W      = 88;

  localparam logic [15:0] SPHERE_RESET = 16'd26214;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_POS_X = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_POS_Y = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_POS_Z = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_VEL_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_VEL_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_VEL_Z = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE    = 4'd7;

  // accumulator slots
  localparam logic [3:0] T_XX = 4'd0;
  localparam logic [3:0] T_XY = 4'd1;
  localparam logic [3:0] T_XZ = 4'd2;
  localparam logic [3:0] T_YY = 4'd3;
  localparam logic [3:0] T_YZ = 4'd4;
  localparam logic [3:0] T_ZZ = 4'd5;
  localparam logic [3:0] T_SX = 4'd6;
  localparam logic [3:0] T_SY = 4'd7;
  localparam logic [3:0] T_SZ = 4'd8;

  localparam logic [4:0] PRE_LAST = 5'd16;
  localparam logic [2:0] SUB_LAST = 3'd5;

  typedef struct packed {
    logic [AGG_W-1:0]  agg_id;
    logic [31:0]       mass;
    logic [31:0]       softening;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic              first;
  } in_data_t;

  typedef struct packed {
    logic signed [63:0] inertia_xx;
    logic signed [63:0] inertia_xy;
    logic signed [63:0] inertia_xz;
    logic signed [63:0] inertia_yy;
    logic signed [63:0] inertia_yz;
    logic signed [63:0] inertia_zz;
    logic signed [63:0] spin_x;
    logic signed [63:0] spin_y;
    logic signed [63:0] spin_z;
    logic signed [31:0] rel_pos_x;
    logic signed [31:0] rel_pos_y;
    logic signed [31:0] rel_pos_z;
  } out_data_t;

  typedef enum logic [1:0] {S_IDLE, S_PROD, S_TERM, S_DONE} state_t;

  typedef enum logic [2:0] {A_RX, A_RY, A_RZ, A_SFT, A_S2L, A_S2H, A_M} asel_t;

  typedef enum logic [3:0] {
    B_RX, B_RY, B_RZ, B_VX, B_VY, B_VZ, B_SFT, B_SF, B_TL, B_TH
  } bsel_t;

  // op acts on the product registered in the previous step
  typedef enum logic [4:0] {
    OP_NOP, OP_PXX, OP_PYY, OP_PZZ, OP_PXY, OP_PXZ, OP_PYZ,
    OP_CA, OP_CR0, OP_CR1, OP_CR2, OP_S2, OP_WLO, OP_GH,
    OP_TERM, OP_WHI, OP_SAT, OP_ACC
  } op_t;

  typedef struct packed {
    asel_t asel;
    bsel_t bsel;
    op_t   op;
  } mstep_t;

  typedef struct packed {
    logic       load;
    logic       out_load;
    mstep_t     step;
    logic [3:0] k;
  } cmd_t;

  function automatic mstep_t pre_step(input logic [4:0] s);
    mstep_t m;
    m = '{A_RX, B_RX, OP_NOP};
    case (s)
      5'd0:  m = '{A_RX,  B_RX,  OP_NOP};
      5'd1:  m = '{A_RY,  B_RY,  OP_PXX};
      5'd2:  m = '{A_RZ,  B_RZ,  OP_PYY};
      5'd3:  m = '{A_RX,  B_RY,  OP_PZZ};
      5'd4:  m = '{A_RX,  B_RZ,  OP_PXY};
      5'd5:  m = '{A_RY,  B_RZ,  OP_PXZ};
      5'd6:  m = '{A_RY,  B_VZ,  OP_PYZ};
      5'd7:  m = '{A_RZ,  B_VY,  OP_CA};
      5'd8:  m = '{A_RZ,  B_VX,  OP_CR0};
      5'd9:  m = '{A_RX,  B_VZ,  OP_CA};
      5'd10: m = '{A_RX,  B_VY,  OP_CR1};
      5'd11: m = '{A_RY,  B_VX,  OP_CA};
      5'd12: m = '{A_SFT, B_SFT, OP_CR2};
      5'd13: m = '{A_RX,  B_RX,  OP_S2};
      5'd14: m = '{A_S2L, B_SF,  OP_NOP};
      5'd15: m = '{A_S2H, B_SF,  OP_WLO};
      5'd16: m = '{A_RX,  B_RX,  OP_GH};
      default: m = '{A_RX, B_RX, OP_NOP};
    endcase
    return m;
  endfunction

  function automatic mstep_t term_step(input logic [2:0] s);
    mstep_t m;
    m = '{A_RX, B_RX, OP_NOP};
    case (s)
      3'd0: m = '{A_RX, B_RX, OP_TERM};
      3'd1: m = '{A_M,  B_TL, OP_NOP};
      3'd2: m = '{A_M,  B_TH, OP_WLO};
      3'd3: m = '{A_RX, B_RX, OP_WHI};
      3'd4: m = '{A_RX, B_RX, OP_SAT};
      3'd5: m = '{A_RX, B_RX, OP_ACC};
      default: m = '{A_RX, B_RX, OP_NOP};
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> sv/itc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_in_if
// Particle input channel.
// ----------------------------------------------------------------------------
interface itc_in_if import itc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/itc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_out_if
// Result channel: running sums and relative position.
// ----------------------------------------------------------------------------
interface itc_out_if import itc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/itc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface itc_cfg_if import itc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/itc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_ctrl
// Sequencer: walks the product steps, then six steps per accumulator term; a non-matching particle skips to the result.
// ----------------------------------------------------------------------------
module itc_ctrl import itc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  input  wire logic match,
  output cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [3:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      sub_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sub_r       <= sub_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sub_nxt       = sub_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '{1'b0, 1'b0, '{A_RX, B_RX, OP_NOP}, 4'd0};
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.step = pre_step(step_r);
        if (!match) begin
          state_nxt = S_DONE;
        end else if (step_r == PRE_LAST) begin
          sub_nxt   = '0;
          k_nxt     = T_XX;
          state_nxt = S_TERM;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_TERM: begin
        cmd.step = term_step(sub_r);
        cmd.k    = k_r;
        if (sub_r == SUB_LAST) begin
          sub_nxt = '0;
          if (k_r == T_SZ) state_nxt = S_DONE;
          else k_nxt = k_r + 4'd1;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      S_DONE: begin
        // output register frees up when the held result is taken
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> sv/itc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itc_dpath
// Registers, shared 33x33 multiplier, term build, saturating accumulators.
// ----------------------------------------------------------------------------
module itc_dpath import itc_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  input  wire in_data_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       match,
  output out_data_t                  out_data
);

  localparam int CMP_BITS = (ID_BITS < AGG_W) ? ID_BITS : AGG_W;

  logic [AGG_W-1:0]   tgt_r;
  logic signed [31:0] cpos_r [3];
  logic signed [31:0] cvel_r [3];
  logic [15:0]        sf_r;

  logic               match_r;
  logic [31:0]        m_r, sft_r;
  logic signed [31:0] rel_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [65:0] prod_r;
  logic signed [47:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r, ca_r;
  logic signed [48:0] cr_r [3];
  logic [47:0]        s2_r, g_r;
  logic signed [TERM_W-1:0] t_r;
  logic signed [WIDE_W-1:0] wide_r;
  logic signed [63:0] q_r;
  logic signed [63:0] sums_r [N_SUMS];
  out_data_t          out_r;

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return d[31:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] sx48(input logic signed [47:0] p);
    return {{(TERM_W-48){p[47]}}, p};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        cpos_r[i] <= '0;
        cvel_r[i] <= '0;
      end
      sf_r <= SPHERE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET:    tgt_r     <= cfg_data[AGG_W-1:0];
        CFG_COM_POS_X: cpos_r[0] <= cfg_data;
        CFG_COM_POS_Y: cpos_r[1] <= cfg_data;
        CFG_COM_POS_Z: cpos_r[2] <= cfg_data;
        CFG_COM_VEL_X: cvel_r[0] <= cfg_data;
        CFG_COM_VEL_Y: cvel_r[1] <= cfg_data;
        CFG_COM_VEL_Z: cvel_r[2] <= cfg_data;
        CFG_SPHERE:    sf_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic in_match;
  assign in_match = (in_data.agg_id[CMP_BITS-1:0] == tgt_r[CMP_BITS-1:0]);

  // multiplier operands
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    case (cmd.step.asel)
      A_RX:    mul_a = {rel_r[0][31], rel_r[0]};
      A_RY:    mul_a = {rel_r[1][31], rel_r[1]};
      A_RZ:    mul_a = {rel_r[2][31], rel_r[2]};
      A_SFT:   mul_a = {1'b0, sft_r};
      A_S2L:   mul_a = {1'b0, s2_r[31:0]};
      A_S2H:   mul_a = {17'b0, s2_r[47:32]};
      A_M:     mul_a = {1'b0, m_r};
      default: mul_a = '0;
    endcase
    case (cmd.step.bsel)
      B_RX:    mul_b = {rel_r[0][31], rel_r[0]};
      B_RY:    mul_b = {rel_r[1][31], rel_r[1]};
      B_RZ:    mul_b = {rel_r[2][31], rel_r[2]};
      B_VX:    mul_b = {vel_r[0][31], vel_r[0]};
      B_VY:    mul_b = {vel_r[1][31], vel_r[1]};
      B_VZ:    mul_b = {vel_r[2][31], vel_r[2]};
      B_SFT:   mul_b = {1'b0, sft_r};
      B_SF:    mul_b = {17'b0, sf_r};
      B_TL:    mul_b = {1'b0, t_r[31:0]};
      B_TH:    mul_b = {{(65-TERM_W){t_r[TERM_W-1]}}, t_r[TERM_W-1:32]};
      default: mul_b = '0;
    endcase
  end

  // floor(product / 2^16) of a Q16.16 x Q16.16 product
  logic signed [47:0] prod_p;
  assign prod_p = prod_r[63:16];

  logic signed [TERM_W-1:0] gr2, term_val;
  assign gr2 = {{(TERM_W-50){1'b0}}, g_r, 2'b00};
  always_comb begin
    case (cmd.k)
      T_XX:    term_val = gr2 + sx48(pyy_r) + sx48(pzz_r);
      T_XY:    term_val = sx48(pxy_r);
      T_XZ:    term_val = sx48(pxz_r);
      T_YY:    term_val = gr2 + sx48(pxx_r) + sx48(pzz_r);
      T_YZ:    term_val = sx48(pyz_r);
      T_ZZ:    term_val = gr2 + sx48(pxx_r) + sx48(pyy_r);
      T_SX:    term_val = {{(TERM_W-49){cr_r[0][48]}}, cr_r[0]};
      T_SY:    term_val = {{(TERM_W-49){cr_r[1][48]}}, cr_r[1]};
      T_SZ:    term_val = {{(TERM_W-49){cr_r[2][48]}}, cr_r[2]};
      default: term_val = '0;
    endcase
  end

  logic [63:0] gsum;
  assign gsum = wide_r[63:0] + {prod_r[31:0], 32'b0};

  logic signed [71:0] sh;
  logic               sh_ovf;
  assign sh     = wide_r[WIDE_W-1:16];
  assign sh_ovf = !((&sh[71:63]) || !(|sh[71:63]));

  logic signed [63:0] acc_a;
  logic signed [64:0] acc_s;
  logic               acc_sub;
  assign acc_a   = sums_r[cmd.k];
  assign acc_sub = (cmd.k == T_XY) || (cmd.k == T_XZ) || (cmd.k == T_YZ);
  assign acc_s   = acc_sub ? ({acc_a[63], acc_a} - {q_r[63], q_r})
                           : ({acc_a[63], acc_a} + {q_r[63], q_r});

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      m_r   <= in_data.mass;
      sft_r <= in_data.softening;
      rel_r[0] <= in_match ? sat_diff(in_data.pos_x, cpos_r[0]) : 32'sd0;
      rel_r[1] <= in_match ? sat_diff(in_data.pos_y, cpos_r[1]) : 32'sd0;
      rel_r[2] <= in_match ? sat_diff(in_data.pos_z, cpos_r[2]) : 32'sd0;
      vel_r[0] <= sat_diff(in_data.vel_x, cvel_r[0]);
      vel_r[1] <= sat_diff(in_data.vel_y, cvel_r[1]);
      vel_r[2] <= sat_diff(in_data.vel_z, cvel_r[2]);
    end
    case (cmd.step.op)
      OP_PXX:  pxx_r <= prod_p;
      OP_PYY:  pyy_r <= prod_p;
      OP_PZZ:  pzz_r <= prod_p;
      OP_PXY:  pxy_r <= prod_p;
      OP_PXZ:  pxz_r <= prod_p;
      OP_PYZ:  pyz_r <= prod_p;
      OP_CA:   ca_r  <= prod_p;
      OP_CR0:  cr_r[0] <= {ca_r[47], ca_r} - {prod_p[47], prod_p};
      OP_CR1:  cr_r[1] <= {ca_r[47], ca_r} - {prod_p[47], prod_p};
      OP_CR2:  cr_r[2] <= {ca_r[47], ca_r} - {prod_p[47], prod_p};
      OP_S2:   s2_r  <= prod_r[63:16];
      OP_WLO:  wide_r <= {{(WIDE_W-64){1'b0}}, prod_r[63:0]};
      OP_GH:   g_r   <= gsum[63:16];
      OP_TERM: t_r   <= term_val;
      OP_WHI:  wide_r <= wide_r + {prod_r[WIDE_W-33:0], 32'b0};
      OP_SAT:  q_r   <= sh_ovf ? (sh[71] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                               : sh[63:0];
      default: ;
    endcase
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_SUMS; i++) sums_r[i] <= '0;
      match_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        match_r <= in_match;
        if (in_data.first) begin
          for (int i = 0; i < N_SUMS; i++) sums_r[i] <= '0;
        end
      end
      if (cmd.step.op == OP_ACC) begin
        if (acc_s[64] != acc_s[63])
          sums_r[cmd.k] <= acc_s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
          sums_r[cmd.k] <= acc_s[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.inertia_xx <= sums_r[T_XX];
      out_r.inertia_xy <= sums_r[T_XY];
      out_r.inertia_xz <= sums_r[T_XZ];
      out_r.inertia_yy <= sums_r[T_YY];
      out_r.inertia_yz <= sums_r[T_YZ];
      out_r.inertia_zz <= sums_r[T_ZZ];
      out_r.spin_x     <= sums_r[T_SX];
      out_r.spin_y     <= sums_r[T_SY];
      out_r.spin_z     <= sums_r[T_SZ];
      out_r.rel_pos_x  <= rel_r[0];
      out_r.rel_pos_y  <= rel_r[1];
      out_r.rel_pos_z  <= rel_r[2];
    end
  end

  assign match    = match_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

>>> sv/inertia_tensor_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inertia_tensor_accumulator
// Per-aggregate inertia tensor and angular momentum sums, Q16.16 in, Q48.16 out.
// ----------------------------------------------------------------------------
// One particle per transaction, one result per particle. For a matching particle
// one shared 33x33 multiplier runs 17 steps for the position, cross and radius
// products, then 6 steps for each of the nine sums (build the term, two partial
// products by the mass, combine, saturate, accumulate). A particle whose id does
// not match skips these steps and goes straight to its result. The next particle
// is accepted while a finished result waits in the output register.
// Config writes are always ready and must happen while no particle is in work.
module inertia_tensor_accumulator import itc_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  itc_in_if.sink    in_ch,
  itc_out_if.source out_ch,
  itc_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  logic match;

  itc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .match     (match),
    .cmd       (cmd)
  );

  itc_dpath #(.ID_BITS(ID_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .match     (match),
    .out_data  (out_ch.data)
  );

  assign cfg_ch.ready = 1'b1;

endmodule
`default_nettype wire
